[rtl/core/salru_pkg.sv]
package salru_pkg;

    localparam int ADDR_BITS  = 32;
    localparam int LINE_BYTES = 64;
    localparam int SETS       = 64;
    localparam int WAYS       = 4;

    localparam int OFF_BITS  = $clog2(LINE_BYTES);
    localparam int SET_BITS  = $clog2(SETS);
    localparam int WAY_BITS  = $clog2(WAYS);
    localparam int RANK_BITS = WAY_BITS;
    localparam int LINE_BITS = ADDR_BITS - OFF_BITS;
    localparam int TAG_WIDTH = LINE_BITS - SET_BITS;

    // access kinds
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic [TAG_WIDTH-1:0] tag;
        logic                 dirty;
        logic [RANK_BITS-1:0] rank;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    typedef struct packed {
        logic                 hit;
        logic [WAY_BITS-1:0]  way;
        logic [SET_BITS-1:0]  set_index;
        logic                 writeback;
        logic [LINE_BITS-1:0] victim_line_address;
        logic                 fill;
        logic [LINE_BITS-1:0] fill_line_address;
        logic                 write_through;
    } t_result;

endpackage

[rtl/core/set_assoc_lru_cache_controller.sv]
// channel  | direction | transfer when                  | payload
// ---------+-----------+--------------------------------+----------------------------------
// access   | in        | start && !busy                 | i_mode, i_address
// result   | out       | o_valid (one cycle, no stall)  | o_hit .. o_write_through
// config   | in        | i_cfg_valid && o_cfg_ready     | i_cfg_copy_back
//
// one access per cycle sustained; busy is never raised
// o_valid follows the access transfer through the lookup register r_s1_valid and the
// result register r_out_valid; the result transfers while o_valid is high
// set row read registered at transfer, way compare and update in the next cycle
// a back-to-back access to the same set takes the updated row from a bypass register
// synchronous active-low reset clears valid bits at once, copy-back mode resets to 1
// the receiver cannot stall, so nothing holds results back
module set_assoc_lru_cache_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic [salru_pkg::ADDR_BITS-1:0] i_address,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_copy_back,
    output logic                            o_valid,
    output logic                            o_hit,
    output logic [salru_pkg::WAY_BITS-1:0]  o_way,
    output logic [salru_pkg::SET_BITS-1:0]  o_set_index,
    output logic                            o_writeback,
    output logic [salru_pkg::LINE_BITS-1:0] o_victim_line_address,
    output logic                            o_fill,
    output logic [salru_pkg::LINE_BITS-1:0] o_fill_line_address,
    output logic                            o_write_through
);

    // configuration
    logic r_copy_back;

    // lookup stage
    logic                            r_s1_valid;
    logic                            r_mode;
    logic [salru_pkg::LINE_BITS-1:0] r_line;
    logic                            r_byp;
    salru_pkg::t_row                 r_byp_row;

    // per-way valid bits, cleared by reset
    logic [salru_pkg::WAYS-1:0] r_valid [salru_pkg::SETS];

    // result register
    logic                r_out_valid;
    salru_pkg::t_result  r_out;

    logic                            accept;
    logic [salru_pkg::SET_BITS-1:0]  in_set;
    logic [salru_pkg::SET_BITS-1:0]  s1_set;
    salru_pkg::t_row                 ram_row;
    salru_pkg::t_row                 cur_row;
    salru_pkg::t_row                 new_row;
    logic [salru_pkg::WAYS-1:0]      new_valid;
    salru_pkg::t_result              result;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign in_set      = i_address[salru_pkg::OFF_BITS +: salru_pkg::SET_BITS];
    assign s1_set      = r_line[salru_pkg::SET_BITS-1:0];
    assign cur_row     = r_byp ? r_byp_row : ram_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_copy_back <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_copy_back <= i_cfg_copy_back;
        end
    end

    // tag, dirty and rank rows; the row is read while the access transfers
    salru_row_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (s1_set),
        .i_wdata (new_row),
        .i_raddr (in_set),
        .o_rdata (ram_row)
    );

    salru_lookup u_lookup (
        .i_row        (cur_row),
        .i_valid      (r_valid[s1_set]),
        .i_mode       (r_mode),
        .i_copy_back  (r_copy_back),
        .i_line       (r_line),
        .o_row        (new_row),
        .o_valid      (new_valid),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= accept;
            r_out_valid <= r_s1_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode    <= i_mode;
        r_line    <= i_address[salru_pkg::ADDR_BITS-1:salru_pkg::OFF_BITS];
        // the ram read misses the row written at this same edge
        r_byp     <= r_s1_valid && (s1_set == in_set);
        r_byp_row <= new_row;
        r_out     <= result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < salru_pkg::SETS; s++) begin
                r_valid[s] <= '0;
            end
        end else if (r_s1_valid) begin
            r_valid[s1_set] <= new_valid;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_hit                 = r_out.hit;
    assign o_way                 = r_out.way;
    assign o_set_index           = r_out.set_index;
    assign o_writeback           = r_out.writeback;
    assign o_victim_line_address = r_out.victim_line_address;
    assign o_fill                = r_out.fill;
    assign o_fill_line_address   = r_out.fill_line_address;
    assign o_write_through       = r_out.write_through;

    // every result is either a hit or a fill request
    a_hit_xor_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit != o_fill))
        else $error("hit and fill disagree");

    // a writeback only comes with a fill
    a_wb_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_writeback) |-> o_fill)
        else $error("writeback without fill");

    // a strobe follows an access transfer through the lookup and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_valid)
        else $error("result strobe missing");

    // the touched way is valid once the lookup stage has written back
    a_way_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> new_valid[result.way])
        else $error("selected way left invalid");

endmodule

[rtl/core/salru_row_ram.sv]
module salru_row_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [salru_pkg::SET_BITS-1:0] i_waddr,
    input  salru_pkg::t_row               i_wdata,
    input  logic [salru_pkg::SET_BITS-1:0] i_raddr,
    output salru_pkg::t_row               o_rdata
);

    salru_pkg::t_row r_mem [salru_pkg::SETS];
    salru_pkg::t_row r_rdata;

    // read returns the old row on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/salru_lookup.sv]
module salru_lookup (
    input  salru_pkg::t_row                 i_row,
    input  logic [salru_pkg::WAYS-1:0]      i_valid,
    input  logic                            i_mode,
    input  logic                            i_copy_back,
    input  logic [salru_pkg::LINE_BITS-1:0] i_line,
    output salru_pkg::t_row                 o_row,
    output logic [salru_pkg::WAYS-1:0]      o_valid,
    output salru_pkg::t_result              o_result
);

    salru_pkg::t_row                   eff;
    salru_pkg::t_row                   upd;
    logic [salru_pkg::TAG_WIDTH-1:0]   tag;
    logic [salru_pkg::SET_BITS-1:0]    set_idx;
    logic                              hit;
    logic                              any_inv;
    logic [salru_pkg::WAY_BITS-1:0]    hit_way;
    logic [salru_pkg::WAY_BITS-1:0]    inv_way;
    logic [salru_pkg::WAY_BITS-1:0]    lru_way;
    logic [salru_pkg::WAY_BITS-1:0]    way;
    logic [salru_pkg::RANK_BITS-1:0]   best;
    logic [salru_pkg::RANK_BITS-1:0]   old_rank;
    logic                              is_write;
    logic [salru_pkg::WAYS-1:0]        upd_valid;

    always_comb begin
        tag      = i_line[salru_pkg::LINE_BITS-1 -: salru_pkg::TAG_WIDTH];
        set_idx  = i_line[salru_pkg::SET_BITS-1:0];
        is_write = (i_mode == salru_pkg::MODE_WRITE);

        // an entry never written reads as its reset value
        eff = i_row;
        for (int j = 0; j < salru_pkg::WAYS; j++) begin
            if (!i_valid[j]) begin
                eff[j] = '0;
            end
        end

        // first matching way, first invalid way
        hit     = 1'b0;
        hit_way = '0;
        any_inv = 1'b0;
        inv_way = '0;
        for (int j = salru_pkg::WAYS - 1; j >= 0; j--) begin
            if (i_valid[j] && (eff[j].tag == tag)) begin
                hit     = 1'b1;
                hit_way = salru_pkg::WAY_BITS'(j);
            end
            if (!i_valid[j]) begin
                any_inv = 1'b1;
                inv_way = salru_pkg::WAY_BITS'(j);
            end
        end

        // oldest way, lowest index on ties
        best    = eff[0].rank;
        lru_way = '0;
        for (int j = 1; j < salru_pkg::WAYS; j++) begin
            if (eff[j].rank < best) begin
                best    = eff[j].rank;
                lru_way = salru_pkg::WAY_BITS'(j);
            end
        end

        if (hit) begin
            way = hit_way;
        end else if (any_inv) begin
            way = inv_way;
        end else begin
            way = lru_way;
        end

        o_result = '0;
        o_result.hit           = hit;
        o_result.way           = way;
        o_result.set_index     = set_idx;
        o_result.fill          = !hit;
        o_result.write_through = is_write && !i_copy_back;
        if (!hit) begin
            o_result.fill_line_address = i_line;
            if (i_copy_back && i_valid[way] && eff[way].dirty) begin
                o_result.writeback           = 1'b1;
                o_result.victim_line_address = {eff[way].tag, set_idx};
            end
        end

        // rank update: ways newer than the touched one age by one
        upd       = eff;
        upd_valid = i_valid;
        old_rank  = eff[way].rank;
        for (int j = 0; j < salru_pkg::WAYS; j++) begin
            if (eff[j].rank > old_rank) begin
                upd[j].rank = eff[j].rank - 1'b1;
            end
        end
        upd[way].rank = salru_pkg::RANK_BITS'(salru_pkg::WAYS - 1);

        if (hit) begin
            if (is_write && i_copy_back) begin
                upd[way].dirty = 1'b1;
            end
        end else begin
            upd[way].tag   = tag;
            upd[way].dirty = is_write && i_copy_back;
            upd_valid[way] = 1'b1;
        end

        o_row   = upd;
        o_valid = upd_valid;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import salru_pkg::*;

    // kinds of entries in the stimulus queue
    typedef enum logic [1:0] {
        OP_ACCESS,
        OP_CFG,
        OP_DRAIN
    } t_op_kind;

    typedef struct {
        t_op_kind             kind;
        logic                 mode;
        logic [ADDR_BITS-1:0] address;
        logic                 copy_back;
    } t_cache_op;

    // no-gap stretch of the driver, counted in accepted accesses
    localparam int BURST_FIRST = 600;
    localparam int BURST_LAST  = 900;
    localparam int GAP_PERCENT = 30;
    localparam int TAIL_CYCLES = 20;

    logic                 i_clk;
    logic                 i_rst_n          = 1'b0;
    logic                 start            = 1'b0;
    logic                 busy;
    logic                 i_mode           = MODE_READ;
    logic [ADDR_BITS-1:0] i_address        = '0;
    logic                 i_cfg_valid      = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_copy_back  = 1'b0;
    logic                 o_valid;
    logic                 o_hit;
    logic [WAY_BITS-1:0]  o_way;
    logic [SET_BITS-1:0]  o_set_index;
    logic                 o_writeback;
    logic [LINE_BITS-1:0] o_victim_line_address;
    logic                 o_fill;
    logic [LINE_BITS-1:0] o_fill_line_address;
    logic                 o_write_through;

    set_assoc_lru_cache_controller dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_mode                (i_mode),
        .i_address             (i_address),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_copy_back       (i_cfg_copy_back),
        .o_valid               (o_valid),
        .o_hit                 (o_hit),
        .o_way                 (o_way),
        .o_set_index           (o_set_index),
        .o_writeback           (o_writeback),
        .o_victim_line_address (o_victim_line_address),
        .o_fill                (o_fill),
        .o_fill_line_address   (o_fill_line_address),
        .o_write_through       (o_write_through)
    );

    // shadow copy of the tag, valid, dirty and lru arrays plus the mode bit
    logic [TAG_WIDTH-1:0] shadow_tag   [SETS][WAYS];
    logic                 shadow_valid [SETS][WAYS];
    logic                 shadow_dirty [SETS][WAYS];
    logic [RANK_BITS-1:0] shadow_rank  [SETS][WAYS];
    logic                 shadow_copy_back;

    t_cache_op pending_ops[$];
    t_result   expected_results[$];

    // transfers seen by the driver, registered and handed to the checker
    logic                 access_taken   = 1'b0;
    logic                 taken_mode     = MODE_READ;
    logic [ADDR_BITS-1:0] taken_address  = '0;
    logic                 cfg_taken      = 1'b0;
    logic                 taken_cb_value = 1'b0;

    int accesses_sent  = 0;
    int results_seen   = 0;
    int mismatch_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // clear the shadow arrays, copy-back mode after reset
    function automatic void clear_shadow();
        for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
                shadow_tag[s][w]   = '0;
                shadow_valid[s][w] = 1'b0;
                shadow_dirty[s][w] = 1'b0;
                shadow_rank[s][w]  = '0;
            end
        end
        shadow_copy_back = 1'b1;
    endfunction

    // one byte access against the shadow arrays: lookup, victim choice, lru update
    function automatic t_result cache_access(input logic mode,
                                             input logic [ADDR_BITS-1:0] address);
        logic [SET_BITS-1:0]  set_sel;
        logic [TAG_WIDTH-1:0] tag_sel;
        logic [WAY_BITS-1:0]  way_sel;
        logic [RANK_BITS-1:0] oldest;
        logic [RANK_BITS-1:0] prior_rank;
        logic                 picked;
        logic                 is_write;
        t_result              res;
        set_sel  = address[OFF_BITS +: SET_BITS];
        tag_sel  = address[ADDR_BITS-1 -: TAG_WIDTH];
        is_write = (mode == MODE_WRITE);
        res      = '0;
        way_sel  = '0;
        picked   = 1'b0;
        oldest   = '0;

        for (int j = 0; j < WAYS; j++) begin
            if (!picked && shadow_valid[set_sel][j] && shadow_tag[set_sel][j] == tag_sel) begin
                picked  = 1'b1;
                way_sel = WAY_BITS'(j);
            end
        end
        res.hit = picked;

        if (res.hit) begin
            if (is_write && shadow_copy_back)
                shadow_dirty[set_sel][way_sel] = 1'b1;
        end else begin
            // first invalid way, else the lowest way with the oldest rank
            for (int j = 0; j < WAYS; j++) begin
                if (!picked && !shadow_valid[set_sel][j]) begin
                    picked  = 1'b1;
                    way_sel = WAY_BITS'(j);
                end
            end
            if (!picked) begin
                for (int j = 0; j < WAYS; j++) begin
                    if (!picked || shadow_rank[set_sel][j] < oldest) begin
                        picked  = 1'b1;
                        oldest  = shadow_rank[set_sel][j];
                        way_sel = WAY_BITS'(j);
                    end
                end
            end
            if (shadow_copy_back && shadow_valid[set_sel][way_sel]
                    && shadow_dirty[set_sel][way_sel]) begin
                res.writeback           = 1'b1;
                res.victim_line_address = {shadow_tag[set_sel][way_sel], set_sel};
            end
            res.fill              = 1'b1;
            res.fill_line_address = address[ADDR_BITS-1:OFF_BITS];
            shadow_tag[set_sel][way_sel]   = tag_sel;
            shadow_valid[set_sel][way_sel] = 1'b1;
            shadow_dirty[set_sel][way_sel] = is_write && shadow_copy_back;
        end

        // move the used way to most recent, younger ones age by one
        prior_rank = shadow_rank[set_sel][way_sel];
        for (int j = 0; j < WAYS; j++) begin
            if (shadow_rank[set_sel][j] > prior_rank)
                shadow_rank[set_sel][j] = shadow_rank[set_sel][j] - 1'b1;
        end
        shadow_rank[set_sel][way_sel] = RANK_BITS'(WAYS - 1);

        res.way           = way_sel;
        res.set_index     = set_sel;
        res.write_through = is_write && !shadow_copy_back;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [LINE_BITS-1:0] want,
                               input logic [LINE_BITS-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t tb: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic add_access(input logic mode, input logic [ADDR_BITS-1:0] address);
        pending_ops.push_back('{OP_ACCESS, mode, address, 1'b0});
    endtask

    task automatic add_cfg(input logic value);
        pending_ops.push_back('{OP_CFG, MODE_READ, '0, value});
    endtask

    task automatic add_drain();
        pending_ops.push_back('{OP_DRAIN, MODE_READ, '0, 1'b0});
    endtask

    // driver: presents the head of pending_ops, holds it until the transfer
    always @(posedge i_clk) begin
        logic      gap;
        logic      idle;
        t_cache_op head;
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_cfg_valid  <= 1'b0;
            access_taken <= 1'b0;
            cfg_taken    <= 1'b0;
        end else begin
            // hand this edge's transfers to the checker
            access_taken   <= start && !busy;
            taken_mode     <= i_mode;
            taken_address  <= i_address;
            cfg_taken      <= i_cfg_valid && o_cfg_ready;
            taken_cb_value <= i_cfg_copy_back;

            if (start && !busy) begin
                accesses_sent++;
                void'(pending_ops.pop_front());
            end
            if (i_cfg_valid && o_cfg_ready)
                void'(pending_ops.pop_front());

            gap  = !(accesses_sent >= BURST_FIRST && accesses_sent < BURST_LAST)
                   && ($urandom_range(99) < GAP_PERCENT);
            // every accepted access has had its result
            idle = (accesses_sent == results_seen);

            if (start && busy) begin
                // keep the refused access on the ports
            end else if (i_cfg_valid && !o_cfg_ready) begin
                // keep the register write on the ports
            end else if (pending_ops.size() == 0) begin
                start       <= 1'b0;
                i_cfg_valid <= 1'b0;
            end else begin
                head = pending_ops[0];
                case (head.kind)
                    OP_ACCESS: begin
                        i_cfg_valid <= 1'b0;
                        start       <= !gap;
                        i_mode      <= head.mode;
                        i_address   <= head.address;
                    end
                    OP_CFG: begin
                        // register writes only once the pipeline is empty
                        start           <= 1'b0;
                        i_cfg_valid     <= idle && !gap;
                        i_cfg_copy_back <= head.copy_back;
                    end
                    default: begin
                        // hold off until every outstanding result is back
                        start       <= 1'b0;
                        i_cfg_valid <= 1'b0;
                        if (idle)
                            void'(pending_ops.pop_front());
                    end
                endcase
            end
        end
    end

    // checker: predicts last edge's transfers, then compares the result strobe
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_shadow();
            expected_results.delete();
            results_seen <= 0;
        end else begin
            if (cfg_taken)
                shadow_copy_back = taken_cb_value;
            if (access_taken)
                expected_results.push_back(cache_access(taken_mode, taken_address));
            if (o_valid) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t tb: result with none expected, expected none actual set %h",
                             $time, o_set_index);
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit", LINE_BITS'(want.hit), LINE_BITS'(o_hit));
                    check_field("way", LINE_BITS'(want.way), LINE_BITS'(o_way));
                    check_field("set_index", LINE_BITS'(want.set_index),
                                LINE_BITS'(o_set_index));
                    check_field("writeback", LINE_BITS'(want.writeback),
                                LINE_BITS'(o_writeback));
                    check_field("victim_line_address", want.victim_line_address,
                                o_victim_line_address);
                    check_field("fill", LINE_BITS'(want.fill), LINE_BITS'(o_fill));
                    check_field("fill_line_address", want.fill_line_address,
                                o_fill_line_address);
                    check_field("write_through", LINE_BITS'(want.write_through),
                                LINE_BITS'(o_write_through));
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [TAG_WIDTH-1:0] tag_pool [8];
        logic [SET_BITS-1:0]  set_pool [4];
        logic [ADDR_BITS-1:0] address;
        logic                 phase_cb [6];
        int                   roll;

        tag_pool = '{20'h00000, 20'h00001, 20'h00002, 20'h00003,
                     20'hFFFFF, 20'hAAAAA, 20'h55555, 20'h00007};
        set_pool = '{6'd0, 6'd1, 6'd62, 6'd63};
        phase_cb = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

        // directed: cold miss on tag zero, hit, write hit, extreme address
        add_cfg(1'b1);
        add_access(MODE_READ,  32'h0000_0000);
        add_access(MODE_READ,  32'h0000_0000);
        add_access(MODE_WRITE, 32'h0000_003F);
        add_access(MODE_WRITE, 32'hFFFF_FFFF);
        // fill the rest of set 0, then evict the dirty lru way
        add_access(MODE_READ,  32'h0000_1000);
        add_access(MODE_READ,  32'h0000_2000);
        add_access(MODE_READ,  32'h0000_3000);
        add_access(MODE_READ,  32'h0000_4000);
        add_access(MODE_WRITE, 32'h0000_5000);
        add_access(MODE_READ,  32'hFFFF_FFC0);
        // write-through: write hit keeps dirty, write miss fills clean
        add_drain();
        add_cfg(1'b0);
        add_access(MODE_WRITE, 32'hFFFF_FFFF);
        add_access(MODE_WRITE, 32'h0000_6000);
        // dirty line left from copy-back mode evicted silently
        add_access(MODE_READ,  32'h0000_7000);
        add_access(MODE_READ,  32'h0000_8000);
        add_access(MODE_READ,  32'h0000_9000);
        // back to copy-back: evict the all-ones dirty line of set 63
        add_drain();
        add_cfg(1'b1);
        add_access(MODE_READ,  32'h0000_1FC0);
        add_access(MODE_READ,  32'h0000_2FC0);
        add_access(MODE_READ,  32'h0000_3FC0);
        add_access(MODE_READ,  32'h0000_4FC0);

        // random phases, mostly a small tag and set pool so lines get reused
        for (int phase = 0; phase < 6; phase++) begin
            add_drain();
            add_cfg(phase_cb[phase]);
            for (int i = 0; i < 250; i++) begin
                roll = $urandom_range(99);
                if (roll < 25) begin
                    address = $urandom();
                end else if (roll < 65) begin
                    address = {tag_pool[$urandom_range(7)], set_pool[$urandom_range(3)],
                               OFF_BITS'($urandom_range(LINE_BYTES - 1))};
                end else begin
                    address = {tag_pool[$urandom_range(7)], SET_BITS'($urandom_range(SETS - 1)),
                               OFF_BITS'($urandom_range(LINE_BYTES - 1))};
                end
                add_access(1'($urandom_range(1)), address);
                if (phase == 2 && i == 125)
                    add_drain();
            end
        end

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all stimulus out and every expected result back
        @(posedge i_clk);
        while (pending_ops.size() != 0 || start || i_cfg_valid || access_taken
               || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            mismatch_count++;
            $display("%0t tb: results missing, expected %0d more actual 0",
                     $time, expected_results.size());
        end
        if (mismatch_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #1ms;
        $display("tb: done, errors");
        $finish;
    end

endmodule

[files.f]
rtl/core/salru_pkg.sv
rtl/core/salru_row_ram.sv
rtl/core/salru_lookup.sv
rtl/core/set_assoc_lru_cache_controller.sv
tb/tb.sv
